// ===== sv/monomial_exponent_enumerator_macros.svh =====
// Assertion macros used by the checker file mee_props.sv.
`ifndef MONOMIAL_EXPONENT_ENUMERATOR_MACROS_SVH
`define MONOMIAL_EXPONENT_ENUMERATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MEE_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mee assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define MEE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mee assertion failed");

`endif

// ===== sv/mee_pkg.sv =====
// Shared constants, types and codes of the monomial exponent enumerator.
package mee_pkg;

   localparam int MAX_DIMS     = 8;
   localparam int EXP_BITS     = 4;
   localparam int IDX_BITS     = 19;
   localparam int CFG_BITS     = 4;
   localparam int CSR_IDX_BITS = 4;
   localparam int DIM_BITS     = $clog2(MAX_DIMS + 1);
   localparam int EXP_MAX      = (1 << EXP_BITS) - 1;
   localparam int SUM_BITS     = $clog2(MAX_DIMS * EXP_MAX + 2);
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_BITS    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_IDX_BITS-1:0] CSR_DIMENSIONS  = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] CSR_POWER_ORDER = CSR_IDX_BITS'(1);

   typedef logic [EXP_BITS-1:0] exp_type;

   typedef enum logic {
      OP_ADVANCE = 1'b0,
      OP_RESTART = 1'b1
   } op_type;

   typedef struct packed {
      logic   valid;
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic [DIM_BITS-1:0] dims;
      exp_type             order;
   } cfg_type;

endpackage

// ===== sv/mee_channels.sv =====
// Handshake channel interfaces: request, response and register write.
interface mee_req_if import mee_pkg::*; ();
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
endinterface

interface mee_rsp_if import mee_pkg::*; ();
   logic                valid;
   logic                ready;
   exp_type             exponent_0;
   exp_type             exponent_1;
   exp_type             exponent_2;
   exp_type             exponent_3;
   exp_type             exponent_4;
   exp_type             exponent_5;
   exp_type             exponent_6;
   exp_type             exponent_7;
   logic [IDX_BITS-1:0] basis_index;
   logic                last_basis;

   modport source (output valid, output exponent_0, output exponent_1, output exponent_2,
                   output exponent_3, output exponent_4, output exponent_5,
                   output exponent_6, output exponent_7, output basis_index,
                   output last_basis, input ready);
   modport sink (input valid, input exponent_0, input exponent_1, input exponent_2,
                 input exponent_3, input exponent_4, input exponent_5, input exponent_6,
                 input exponent_7, input basis_index, input last_basis, output ready);
endinterface

interface mee_csr_if import mee_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [CSR_IDX_BITS-1:0] index;
   logic [CFG_BITS-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/mee_queue.sv =====
// Small command queue between the front and the back.
module mee_queue import mee_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cmd_type push,
   input  logic    pop,
   output cmd_type head,
   output logic    full
);

   op_type               mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full       = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.op    = mem_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                               : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                               : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.op;
      end
   end

endmodule

// ===== sv/mee_front.sv =====
// Request front end: accept beats and classify them as restart or advance.
module mee_front import mee_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   mee_req_if.sink   req_ch,
   input  logic      full,
   output cmd_type   push
);

   logic started_ff, started_in;
   logic accept;

   assign req_ch.ready = !full;
   assign accept       = req_ch.valid && !full;

   // The first beat after reset always starts from the zero tuple.
   assign push.valid = accept;
   assign push.op    = (req_ch.restart || !started_ff) ? OP_RESTART : OP_ADVANCE;
   assign started_in = started_ff || accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
      end else begin
         started_ff <= started_in;
      end
   end

endmodule

// ===== sv/mee_back.sv =====
// Back end: holds the current tuple, steps it and registers the response.
module mee_back import mee_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  cmd_type    head,
   output logic       pop,
   mee_rsp_if.source  rsp_ch
);

   exp_type             exp_ff [MAX_DIMS];
   exp_type             exp_in [MAX_DIMS];
   exp_type             nxt [MAX_DIMS];
   logic [IDX_BITS-1:0] idx_ff, idx_in;
   logic                last_ff, last_in;
   logic                valid_ff, valid_in;
   logic [MAX_DIMS-1:0] fit;
   logic                found;

   // Suffix sums from the top active digit down; a digit fits when bumping it
   // keeps the sum of itself and everything above within the order.
   always_comb begin
      logic [SUM_BITS-1:0] acc;
      exp_type             cur;
      acc = '0;
      for (int i = MAX_DIMS - 1; i >= 0; i--) begin
         cur    = (i < int'(cfg.dims)) ? exp_ff[i] : '0;
         acc    = acc + SUM_BITS'(cur);
         fit[i] = (i < int'(cfg.dims)) &&
                  ((SUM_BITS + 1)'(acc) + (SUM_BITS + 1)'(1) <= (SUM_BITS + 1)'(cfg.order));
      end
   end

   // Lowest fitting digit increments, digits below it clear, inactive ones drop.
   always_comb begin
      logic seen;
      seen = 1'b0;
      for (int i = 0; i < MAX_DIMS; i++) begin
         if (i >= int'(cfg.dims)) begin
            nxt[i] = '0;
         end else if (!seen && fit[i]) begin
            nxt[i] = exp_type'(exp_ff[i] + 1'b1);
            seen   = 1'b1;
         end else if (!seen) begin
            nxt[i] = '0;
         end else begin
            nxt[i] = exp_ff[i];
         end
      end
      found = seen;
   end

   assign pop = head.valid && (!valid_ff || rsp_ch.ready);

   always_comb begin
      exp_in   = exp_ff;
      idx_in   = idx_ff;
      last_in  = last_ff;
      valid_in = valid_ff && !rsp_ch.ready;
      if (pop) begin
         valid_in = 1'b1;
         if (head.op == OP_RESTART || !found) begin
            exp_in = '{default: '0};
            idx_in = '0;
         end else begin
            exp_in = nxt;
            idx_in = idx_ff + 1'b1;
         end
         last_in = 1'b0;
         for (int i = 0; i < MAX_DIMS; i++) begin
            if (i == int'(cfg.dims) - 1) begin
               last_in = (exp_in[i] == cfg.order);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         exp_ff   <= '{default: '0};
         idx_ff   <= '0;
         last_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         exp_ff   <= exp_in;
         idx_ff   <= idx_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_ch.valid       = valid_ff;
   assign rsp_ch.exponent_0  = exp_ff[0];
   assign rsp_ch.exponent_1  = exp_ff[1];
   assign rsp_ch.exponent_2  = exp_ff[2];
   assign rsp_ch.exponent_3  = exp_ff[3];
   assign rsp_ch.exponent_4  = exp_ff[4];
   assign rsp_ch.exponent_5  = exp_ff[5];
   assign rsp_ch.exponent_6  = exp_ff[6];
   assign rsp_ch.exponent_7  = exp_ff[7];
   assign rsp_ch.basis_index = idx_ff;
   assign rsp_ch.last_basis  = last_ff;

endmodule

// ===== sv/monomial_exponent_enumerator.sv =====
// Top level of the monomial exponent enumerator: registers, front, queue, back.
//
//   channel   dir   payload                                   beat taken when
//   req_ch    in    restart                                   valid && ready
//   rsp_ch    out   exponent_0..7, basis_index, last_basis    valid && ready
//   csr_ch    in    index, data                               valid && ready
//
// One tuple per cycle unless rsp_ch stalls; each request is queued, then registered.
// The next tuple comes from a suffix-sum and lowest-fit pick in the back end.
// csr_ch.ready is always high.
// A stalled response fills the two-entry queue, then req_ch.ready drops.
module monomial_exponent_enumerator import mee_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   mee_req_if.sink    req_ch,
   mee_rsp_if.source  rsp_ch,
   mee_csr_if.sink    csr_ch
);

   logic [CFG_BITS-1:0] dims_ff, dims_in;
   logic [CFG_BITS-1:0] order_ff, order_in;
   cfg_type             cfg;
   cmd_type             push;
   cmd_type             head;
   logic                full;
   logic                pop;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      dims_in  = dims_ff;
      order_in = order_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_DIMENSIONS:  dims_in  = csr_ch.data;
            CSR_POWER_ORDER: order_in = csr_ch.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff  <= CFG_BITS'(1);
         order_ff <= CFG_BITS'(1);
      end else begin
         dims_ff  <= dims_in;
         order_ff <= order_in;
      end
   end

   // Clamp dimensions into 1..MAX_DIMS and the order into the exponent range.
   always_comb begin
      if (dims_ff == '0) begin
         cfg.dims = DIM_BITS'(1);
      end else if (int'(dims_ff) > MAX_DIMS) begin
         cfg.dims = DIM_BITS'(MAX_DIMS);
      end else begin
         cfg.dims = DIM_BITS'(dims_ff);
      end
      if (int'(order_ff) > EXP_MAX) begin
         cfg.order = exp_type'(EXP_MAX);
      end else begin
         cfg.order = exp_type'(order_ff);
      end
   end

   mee_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .full   (full),
      .push   (push)
   );

   mee_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .full  (full)
   );

   mee_back u_back (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .head   (head),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule

// ===== sv/mee_props.sv =====
// Port-level checks of the enumerator, bound to the top level.
`include "monomial_exponent_enumerator_macros.svh"

module mee_props import mee_pkg::*; (
   input logic       clock,
   input logic       reset,
   mee_req_if.sink   req_ch,
   mee_rsp_if.source rsp_ch
);

   // A stalled response beat keeps its basis_index and exponent_0.
   `MEE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_ch.valid && !rsp_ch.ready, rsp_ch.valid && $stable(rsp_ch.basis_index) && $stable(rsp_ch.exponent_0))

   // Every accepted request must be followed by a valid response.
   `MEE_ASSERT_NOW(a_rsp_latency, clock, reset, req_ch.valid && req_ch.ready, ##2 rsp_ch.valid)

   // Backpressure on requests only follows a stalled response.
   `MEE_ASSERT_NOW(a_req_stall, clock, reset, !req_ch.ready, $past(rsp_ch.valid && !rsp_ch.ready))

endmodule

bind monomial_exponent_enumerator mee_props u_mee_props (
   .clock  (clock),
   .reset  (reset),
   .req_ch (req_ch),
   .rsp_ch (rsp_ch)
);
